// ----- design/wht_pkg.sv -----
// Shared constants for the window hit test and raise block.
`timescale 1ns / 1ps

package wht_pkg;

    localparam int DEF_MAX_WINDOWS = 16;
    localparam int DEF_COORD_BITS  = 12;
    localparam int NUM_W           = 5;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_CLICK = 1'b1;

endpackage

// ----- design/window_hit_test_raise.sv -----
// Top level: sequencer that loads windows, scans the stack for a click and raises the hit window.
//
// A load takes a transfer only while the sequencer is idle and then rewrites the stack order
// memory, one entry per cycle, to place the new window on top; a load into a full stack is
// taken and dropped at once. A click scans the stack from the top through the stack order
// memory and then the bounds memory, one position per cycle, each read registered, and raising
// the window found at position k shifts the k entries above it down one place and then writes
// the top entry; a click with no window loaded goes straight to the result. The result sits in
// an output register, so the next item can be taken while it waits. Each memory has one read
// port and one write port, and each port moves at most one entry per cycle.
`timescale 1ns / 1ps

module window_hit_test_raise #(
    parameter int MAX_WINDOWS = wht_pkg::DEF_MAX_WINDOWS,
    parameter int COORD_BITS  = wht_pkg::DEF_COORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_kind,
    input  logic [COORD_BITS-1:0]      i_left,
    input  logic [COORD_BITS-1:0]      i_bottom,
    input  logic [COORD_BITS-1:0]      i_right,
    input  logic [COORD_BITS-1:0]      i_upper,
    input  logic [COORD_BITS-1:0]      i_point_x,
    input  logic [COORD_BITS-1:0]      i_point_y,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_hit,
    output logic [wht_pkg::NUM_W-1:0]  o_window_number
);
    import wht_pkg::*;

    localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_TOP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_rd_pos, n_rd_pos;
    logic                  r_s1_valid, n_s1_valid;
    logic [IDX_W-1:0]      r_s1_pos, n_s1_pos;
    logic                  r_s2_valid, n_s2_valid;
    logic [IDX_W-1:0]      r_s2_pos, n_s2_pos;
    logic [IDX_W-1:0]      r_s2_id, n_s2_id;
    logic [IDX_W-1:0]      r_dst, n_dst;
    logic [IDX_W-1:0]      r_id, n_id;
    logic                  r_is_click, n_is_click;
    logic [COORD_BITS-1:0] r_px, n_px;
    logic [COORD_BITS-1:0] r_py, n_py;
    logic                  r_res_hit, n_res_hit;
    logic [NUM_W-1:0]      r_res_num, n_res_num;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_hit, n_out_hit;
    logic [NUM_W-1:0]      r_out_num, n_out_num;

    logic                  stack_we;
    logic [IDX_W-1:0]      stack_waddr;
    logic [IDX_W-1:0]      stack_wdata;
    logic [IDX_W-1:0]      stack_raddr;
    logic [IDX_W-1:0]      stack_rd;
    logic                  bounds_we;
    logic [IDX_W-1:0]      bounds_waddr;
    logic [IDX_W-1:0]      bounds_raddr;
    logic                  bounds_hit;
    logic                  in_xfer;
    logic                  issue;
    logic [IDX_W:0]        id_p1;

    wht_stack #(
        .MAX_WINDOWS(MAX_WINDOWS),
        .IDX_W      (IDX_W)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (stack_we),
        .i_waddr(stack_waddr),
        .i_wdata(stack_wdata),
        .i_raddr(stack_raddr),
        .o_rdata(stack_rd)
    );

    wht_bounds #(
        .MAX_WINDOWS(MAX_WINDOWS),
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_bounds (
        .i_clk   (i_clk),
        .i_we    (bounds_we),
        .i_waddr (bounds_waddr),
        .i_left  (i_left),
        .i_bottom(i_bottom),
        .i_right (i_right),
        .i_upper (i_upper),
        .i_raddr (bounds_raddr),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_hit   (bounds_hit)
    );

    assign o_ready         = (r_state == S_IDLE);
    assign in_xfer         = i_valid && o_ready;
    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_window_number = r_out_num;
    assign issue           = (r_rd_pos < r_count);
    assign id_p1           = {1'b0, r_s2_id} + {{IDX_W{1'b0}}, 1'b1};
    assign bounds_waddr    = r_count[IDX_W-1:0];
    assign bounds_raddr    = stack_rd;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_pos    = r_rd_pos;
        n_s1_valid  = r_s1_valid;
        n_s1_pos    = r_s1_pos;
        n_s2_valid  = r_s2_valid;
        n_s2_pos    = r_s2_pos;
        n_s2_id     = r_s2_id;
        n_dst       = r_dst;
        n_id        = r_id;
        n_is_click  = r_is_click;
        n_px        = r_px;
        n_py        = r_py;
        n_res_hit   = r_res_hit;
        n_res_num   = r_res_num;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_num   = r_out_num;
        stack_we    = 1'b0;
        stack_waddr = r_dst;
        stack_wdata = stack_rd;
        stack_raddr = r_dst - IDX_W'(1);
        bounds_we   = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_is_click = (i_kind == KIND_CLICK);
                    n_px       = i_point_x;
                    n_py       = i_point_y;
                    n_rd_pos   = '0;
                    n_s1_valid = 1'b0;
                    n_s2_valid = 1'b0;
                    if (i_kind == KIND_CLICK) begin
                        if (r_count == '0) begin
                            n_res_hit = 1'b0;
                            n_res_num = '0;
                            n_state   = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (r_count < CNT_W'(MAX_WINDOWS)) begin
                        bounds_we   = 1'b1;
                        n_dst       = r_count[IDX_W-1:0];
                        n_id        = r_count[IDX_W-1:0];
                        n_count     = r_count + CNT_W'(1);
                        stack_raddr = r_count[IDX_W-1:0] - IDX_W'(1);
                        n_state     = (r_count == '0) ? S_TOP : S_SHIFT;
                    end
                end
            end
            S_SCAN: begin
                stack_raddr = r_rd_pos[IDX_W-1:0];
                n_s1_valid  = issue;
                n_s1_pos    = r_rd_pos[IDX_W-1:0];
                n_s2_valid  = r_s1_valid;
                n_s2_pos    = r_s1_pos;
                n_s2_id     = stack_rd;
                if (issue) begin
                    n_rd_pos = r_rd_pos + CNT_W'(1);
                end
                if (r_s2_valid && bounds_hit) begin
                    n_res_hit   = 1'b1;
                    n_res_num   = NUM_W'(id_p1);
                    n_dst       = r_s2_pos;
                    n_id        = r_s2_id;
                    stack_raddr = r_s2_pos - IDX_W'(1);
                    n_state     = (r_s2_pos == '0) ? S_TOP : S_SHIFT;
                end else if (r_s2_valid && (CNT_W'(r_s2_pos) + CNT_W'(1) == r_count)) begin
                    n_res_hit = 1'b0;
                    n_res_num = '0;
                    n_state   = S_DONE;
                end
            end
            S_SHIFT: begin
                stack_we    = 1'b1;
                stack_waddr = r_dst;
                stack_wdata = stack_rd;
                stack_raddr = r_dst - IDX_W'(2);
                n_dst       = r_dst - IDX_W'(1);
                if (r_dst == IDX_W'(1)) begin
                    n_state = S_TOP;
                end
            end
            S_TOP: begin
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = r_id;
                n_state     = r_is_click ? S_DONE : S_IDLE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_res_hit;
                    n_out_num   = r_res_num;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_rd_pos   <= n_rd_pos;
        r_s1_valid <= n_s1_valid;
        r_s1_pos   <= n_s1_pos;
        r_s2_valid <= n_s2_valid;
        r_s2_pos   <= n_s2_pos;
        r_s2_id    <= n_s2_id;
        r_dst      <= n_dst;
        r_id       <= n_id;
        r_is_click <= n_is_click;
        r_px       <= n_px;
        r_py       <= n_py;
        r_res_hit  <= n_res_hit;
        r_res_num  <= n_res_num;
        r_out_hit  <= n_out_hit;
        r_out_num  <= n_out_num;
    end

    // The window count never exceeds the capacity of the memories.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_WINDOWS))
        else $error("window count above capacity");

    // A miss always reports window number zero.
    a_miss_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_hit |-> r_out_num == '0)
        else $error("miss with nonzero window number");

    // The shift never runs with the top position as its destination.
    a_shift_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SHIFT |-> r_dst != '0)
        else $error("shift destination at top of stack");

    // The stack order is never written while a scan reads it.
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> !stack_we)
        else $error("stack written during scan");

    // A load grows the count by one only when there was room for it.
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_kind == KIND_LOAD && r_count < CNT_W'(MAX_WINDOWS)
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("load did not advance the window count");

endmodule

// ----- design/wht_stack.sv -----
// Stack order memory: window indices by stack position, top of stack at address zero.
`timescale 1ns / 1ps

module wht_stack #(
    parameter int MAX_WINDOWS = wht_pkg::DEF_MAX_WINDOWS,
    parameter int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [IDX_W-1:0] i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [IDX_W-1:0] o_rdata
);
    import wht_pkg::*;

    logic [IDX_W-1:0] r_mem [0:MAX_WINDOWS-1];
    logic [IDX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/wht_bounds.sv -----
// Window bounds memory with the containment test on the registered read data.
`timescale 1ns / 1ps

module wht_bounds #(
    parameter int MAX_WINDOWS = wht_pkg::DEF_MAX_WINDOWS,
    parameter int COORD_BITS  = wht_pkg::DEF_COORD_BITS,
    parameter int IDX_W       = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IDX_W-1:0]      i_waddr,
    input  logic [COORD_BITS-1:0] i_left,
    input  logic [COORD_BITS-1:0] i_bottom,
    input  logic [COORD_BITS-1:0] i_right,
    input  logic [COORD_BITS-1:0] i_upper,
    input  logic [IDX_W-1:0]      i_raddr,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    output logic                  o_hit
);
    import wht_pkg::*;

    localparam int REC_W = 4 * COORD_BITS;

    logic [REC_W-1:0]      r_mem [0:MAX_WINDOWS-1];
    logic [REC_W-1:0]      r_rdata;
    logic [COORD_BITS-1:0] lo_x;
    logic [COORD_BITS-1:0] lo_y;
    logic [COORD_BITS-1:0] hi_x;
    logic [COORD_BITS-1:0] hi_y;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_left, i_bottom, i_right, i_upper};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign {lo_x, lo_y, hi_x, hi_y} = r_rdata;

    assign o_hit = (lo_x <= i_px) && (hi_x >= i_px) && (lo_y <= i_py) && (hi_y >= i_py);

endmodule
